### src/bifr_pkg.sv
// ----------------------------------------------------------------------------
// bifr_pkg
// shared types and constants for the bitmap invert / flip / rotate block
// ----------------------------------------------------------------------------
package bifr_pkg;

    // configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // stream payload widths (whole bytes)
    localparam int TDATA_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_INVERT = 3'd2,
        CFG_MIRROR = 3'd3,
        CFG_ROTATE = 3'd4
    } t_cfg_idx;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // write pixel, advance load count
        logic fetch;  // compute source address, advance output position
        logic read;   // read store into output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic slot_free;  // output register empty or being taken this cycle
    } t_stat;

endpackage

### src/bitmap_invert_flip_rotate.sv
// ----------------------------------------------------------------------------
// bitmap_invert_flip_rotate
// one-bit frame store with inversion, left-right mirror and 90 degree
// counterclockwise rotation applied on readout
// ----------------------------------------------------------------------------
// timing: a load is written at the edge that accepts it; a fetch registers
//   its source address, then the store read fills the output register
// throughput: one load per cycle while no fetch is in progress; a fetch
//   closes the input until its read finds room in the output register
// reset: synchronous active low; clears counters and output valid, resets config;
//   store not cleared: entries must be loaded before read, not enforced here
module bitmap_invert_flip_rotate #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bifr_pkg::TDATA_W-1:0]    s_axis_tdata,  // [0] pixel_in, rest unused
    input  logic                            s_axis_tuser,  // [0] action: 0 load, 1 fetch

    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bifr_pkg::TDATA_W-1:0]    m_axis_tdata,  // [0] pixel_out, rest zero
    output logic                            m_axis_tlast,  // row_end
    output logic                            m_axis_tuser,  // [0] frame_end

    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bifr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bifr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bifr_pkg::t_cmd  cmd;
    bifr_pkg::t_stat stat;
    logic            pixel_out;

    // config writes are always taken and land at the accepting edge
    assign o_cfg_ready = 1'b1;

    // controller: handshake on the input side, sequences fetch then read
    bifr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: store, counters, address math and output register
    bifr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (s_axis_tdata[0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_pixel     (pixel_out),
        .o_row_end   (m_axis_tlast),
        .o_frame_end (m_axis_tuser)
    );

    // pad pixel to a whole byte
    assign m_axis_tdata = {{(bifr_pkg::TDATA_W-1){1'b0}}, pixel_out};

endmodule

### src/bifr_ctrl.sv
// ----------------------------------------------------------------------------
// bifr_ctrl
// controller: accepts beats, issues load / fetch / read commands
// ----------------------------------------------------------------------------
module bifr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    output logic             o_in_ready,
    input  bifr_pkg::t_stat  i_stat,
    output bifr_pkg::t_cmd   o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   accept;

    assign accept     = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    assign o_cmd.load  = accept && !i_action;
    assign o_cmd.fetch = accept && i_action;
    assign o_cmd.read  = (r_state == S_READ) && i_stat.slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_action) begin
                        r_state    <= S_READ;
                        r_in_ready <= 1'b0;
                    end
                end
                S_READ: begin
                    // wait for room in the output register
                    if (i_stat.slot_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

### src/bifr_datapath.sv
// ----------------------------------------------------------------------------
// bifr_datapath
// config registers, frame store, load / output counters, output register
// ----------------------------------------------------------------------------
module bifr_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bifr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bifr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_pixel,
    input  bifr_pkg::t_cmd                  i_cmd,
    output bifr_pkg::t_stat                 o_stat,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_pixel,
    output logic                            o_row_end,
    output logic                            o_frame_end
);

    localparam int CFG_MAX  = (1 << bifr_pkg::CFG_DATA_W) - 1;
    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_MAX  = (MAX_DIM > CFG_MAX) ? CFG_MAX : MAX_DIM;
    localparam int EW       = $clog2(DIM_MAX + 1);
    localparam int CW       = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW       = $clog2(DEPTH + 1);

    function automatic logic [EW-1:0] f_clamp(
        input logic [bifr_pkg::CFG_DATA_W-1:0] v,
        input int                              maxv
    );
        logic [EW-1:0] res;
        if (v == '0) begin
            res = EW'(1);
        end else if (int'(v) > maxv) begin
            res = EW'(maxv);
        end else begin
            res = EW'(v);
        end
        return res;
    endfunction

    localparam logic [EW-1:0] W_RST = f_clamp(bifr_pkg::CFG_DATA_W'(64), MAX_WIDTH);
    localparam logic [EW-1:0] H_RST = f_clamp(bifr_pkg::CFG_DATA_W'(64), MAX_HEIGHT);

    // configuration, stored as effective (saturated) sizes
    logic [EW-1:0] r_w;
    logic [EW-1:0] r_h;
    logic          r_inv;
    logic          r_mir;
    logic          r_rot;

    logic [LW-1:0] r_lcnt;
    logic [CW-1:0] r_orow;
    logic [CW-1:0] r_ocol;

    logic [AW-1:0] r_addr;
    logic          r_rend;
    logic          r_fend;

    logic          r_out_valid;
    logic          r_pix;
    logic          r_olast;
    logic          r_ouser;

    logic          mem [DEPTH];

    logic [2*EW-1:0] area_full;
    logic [LW-1:0]   area;
    logic            load_ok;

    logic [EW-1:0]   ow;
    logic [EW-1:0]   oh;
    logic            wrap;
    logic [EW-1:0]   row;
    logic [EW-1:0]   col;
    logic [EW-1:0]   srow;
    logic [EW-1:0]   scol_r;
    logic [EW-1:0]   scol;
    logic [2*EW-1:0] prod;
    logic [2*EW-1:0] src_addr;
    logic            rend;
    logic            fend;

    assign area_full = {EW'(0), r_w} * {EW'(0), r_h};
    assign area      = LW'(area_full);
    assign load_ok   = r_lcnt < area;

    // output position; restart when outside the current output size
    assign ow   = r_rot ? r_h : r_w;
    assign oh   = r_rot ? r_w : r_h;
    assign wrap = (EW'(r_orow) >= oh) || (EW'(r_ocol) >= ow);
    assign row  = wrap ? '0 : EW'(r_orow);
    assign col  = wrap ? '0 : EW'(r_ocol);

    // source pixel: rotate maps output (row, col) to (col, w-1-row)
    assign srow     = r_rot ? col : row;
    assign scol_r   = r_rot ? (r_w - EW'(1) - row) : col;
    assign scol     = r_mir ? (r_w - EW'(1) - scol_r) : scol_r;
    assign prod     = {EW'(0), srow} * {EW'(0), r_w};
    assign src_addr = prod + {EW'(0), scol};

    assign rend = (col == ow - EW'(1));
    assign fend = rend && (row == oh - EW'(1));

    assign o_stat.slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= W_RST;
            r_h         <= H_RST;
            r_inv       <= 1'b0;
            r_mir       <= 1'b0;
            r_rot       <= 1'b0;
            r_lcnt      <= '0;
            r_orow      <= '0;
            r_ocol      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bifr_pkg::CFG_WIDTH:  r_w   <= f_clamp(i_cfg_data, MAX_WIDTH);
                    bifr_pkg::CFG_HEIGHT: r_h   <= f_clamp(i_cfg_data, MAX_HEIGHT);
                    bifr_pkg::CFG_INVERT: r_inv <= i_cfg_data[0];
                    bifr_pkg::CFG_MIRROR: r_mir <= i_cfg_data[0];
                    bifr_pkg::CFG_ROTATE: r_rot <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.load && load_ok) begin
                r_lcnt <= r_lcnt + LW'(1);
            end
            if (i_cmd.fetch) begin
                if (fend) begin
                    r_orow <= '0;
                    r_ocol <= '0;
                end else if (rend) begin
                    r_orow <= CW'(row + EW'(1));
                    r_ocol <= '0;
                end else begin
                    r_orow <= CW'(row);
                    r_ocol <= CW'(col + EW'(1));
                end
            end
            if (i_cmd.read) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and frame store, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            mem[AW'(r_lcnt)] <= i_pixel;
        end
        if (i_cmd.fetch) begin
            r_addr <= AW'(src_addr);
            r_rend <= rend;
            r_fend <= fend;
        end
        if (i_cmd.read) begin
            r_pix   <= mem[r_addr] ^ r_inv;
            r_olast <= r_rend;
            r_ouser <= r_fend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_pix;
    assign o_row_end   = r_olast;
    assign o_frame_end = r_ouser;

endmodule

### src/bifr_checker.sv
// ----------------------------------------------------------------------------
// bifr_checker
// port-level checks for the bitmap invert / flip / rotate block
// ----------------------------------------------------------------------------
module bifr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bifr_pkg::TDATA_W-1:0]    m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tuser
);

    // stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("output beat changed while stalled");

    // end of frame is always also end of row
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end without row end");

    // a fetch blocks input for the next cycle while the store is read
    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
        else $error("input taken during fetch read");

    // a load leaves the input open
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> s_axis_tready)
        else $error("load stalled the input");

    // padding bits of the output byte stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[bifr_pkg::TDATA_W-1:1] == '0))
        else $error("nonzero padding on output");

endmodule

bind bitmap_invert_flip_rotate bifr_checker u_bifr_checker (.*);

### bench/bitmap_invert_flip_rotate_test.sv
// ----------------------------------------------------------------------------
// bitmap_invert_flip_rotate_test
// self-checking bench for the one-bit frame store with invert, mirror and
// rotate on readout: load and fetch beats go in over the input stream, every
// fetched pixel is compared with a prediction kept in a scoreboard object,
// under random stalls on both streams and many frame sizes and transforms
// ----------------------------------------------------------------------------
module bitmap_invert_flip_rotate_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W          = 64;
    localparam int MAX_H          = 64;
    localparam int STORE_DEPTH    = MAX_W * MAX_H;
    localparam int RAND_ITEMS     = 1000;   // random beats that the block acts on
    localparam int MAX_FRAME_PIX  = 512;    // keeps the total number of loads modest
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 4;      // block latency plus margin
    localparam int WATCHDOG_LIMIT = 2000;   // cycles in a row with no beat at all
    localparam int SHOW_LIMIT     = 10;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the frame store, counters and registers
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        typedef struct {
            bit pixel_out;
            bit row_end;
            bit frame_end;
        } t_pixel_beat;

        bit          frame_mem[STORE_DEPTH];
        int unsigned loaded;
        int unsigned row_pos;
        int unsigned col_pos;
        logic [6:0]  width_reg;
        logic [6:0]  height_reg;
        bit          invert_on;
        bit          mirror_on;
        bit          rotate_on;

        t_pixel_beat expected_pixels[$];
        int unsigned errors;
        int unsigned loads_taken;
        int unsigned loads_dropped;
        int unsigned fetches;
        int unsigned frames_seen;

        function new();
            loaded     = 0;
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = 7'd64;
            height_reg = 7'd64;
            invert_on  = 0;
            mirror_on  = 0;
            rotate_on  = 0;
            errors     = 0;
            loads_taken   = 0;
            loads_dropped = 0;
            fetches       = 0;
            frames_seen   = 0;
        endfunction

        // 0 acts as 1, anything over the maximum acts as the maximum
        static function int unsigned clamp_dim(logic [6:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function int unsigned eff_w();
            return clamp_dim(width_reg, MAX_W);
        endfunction

        function int unsigned eff_h();
            return clamp_dim(height_reg, MAX_H);
        endfunction

        function int unsigned out_w();
            return rotate_on ? eff_h() : eff_w();
        endfunction

        function int unsigned out_h();
            return rotate_on ? eff_w() : eff_h();
        endfunction

        function bit can_load();
            return loaded < eff_w() * eff_h();
        endfunction

        function void set_reg(bifr_pkg::t_cfg_idx idx, logic [6:0] v);
            case (idx)
                bifr_pkg::CFG_WIDTH:  width_reg  = v;
                bifr_pkg::CFG_HEIGHT: height_reg = v;
                bifr_pkg::CFG_INVERT: invert_on  = v[0];
                bifr_pkg::CFG_MIRROR: mirror_on  = v[0];
                bifr_pkg::CFG_ROTATE: rotate_on  = v[0];
                default: ;
            endcase
        endfunction

        // store entry that output position (r, c) maps to
        function int unsigned source_addr(int unsigned r, int unsigned c);
            int unsigned w;
            int unsigned srow;
            int unsigned scol;
            w = eff_w();
            if (rotate_on) begin
                srow = c;
                scol = w - 1 - r;
            end else begin
                srow = r;
                scol = c;
            end
            if (mirror_on) scol = w - 1 - scol;
            return (srow * w + scol) % STORE_DEPTH;
        endfunction

        // address the next fetch would read, counters left alone
        function int unsigned next_fetch_addr();
            int unsigned r;
            int unsigned c;
            r = row_pos;
            c = col_pos;
            if (r >= out_h() || c >= out_w()) begin
                r = 0;
                c = 0;
            end
            return source_addr(r, c);
        endfunction

        function bit fetch_is_safe();
            return next_fetch_addr() < loaded;
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        // accepted input beat: load writes the store, fetch queues a pixel
        function void note_input(bit action, bit pix);
            int unsigned r;
            int unsigned c;
            t_pixel_beat p;
            if (action == 1'b0) begin
                if (can_load()) begin
                    frame_mem[loaded % STORE_DEPTH] = pix;
                    loaded++;
                    loads_taken++;
                end else begin
                    loads_dropped++;
                end
                return;
            end
            r = row_pos;
            c = col_pos;
            // position left over from an older, larger setting restarts
            if (r >= out_h() || c >= out_w()) begin
                r = 0;
                c = 0;
            end
            p.pixel_out = frame_mem[source_addr(r, c)] ^ invert_on;
            p.row_end   = (c == out_w() - 1);
            p.frame_end = p.row_end && (r == out_h() - 1);
            expected_pixels.push_back(p);
            fetches++;
            if (p.row_end) begin
                c = 0;
                r = p.frame_end ? 0 : r + 1;
            end else begin
                c++;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void check_result(bit pix, bit rend, bit fend);
            t_pixel_beat p;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display({"[%0t] unexpected output beat: ",
                              "pixel %0b row_end %0b frame_end %0b"},
                             $realtime, pix, rend, fend);
                return;
            end
            p = expected_pixels.pop_front();
            if (p.frame_end) frames_seen++;
            if (p.pixel_out !== pix || p.row_end !== rend || p.frame_end !== fend) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display({"[%0t] mismatch: expected pixel %0b row_end %0b ",
                              "frame_end %0b, got %0b %0b %0b"},
                             $realtime, p.pixel_out, p.row_end, p.frame_end,
                             pix, rend, fend);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bifr_pkg::TDATA_W-1:0]    s_axis_tdata  = '0;    // [0] pixel_in, rest zero
    logic                            s_axis_tuser  = 1'b0;  // [0] action: 0 load, 1 fetch
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [bifr_pkg::TDATA_W-1:0]    m_axis_tdata;          // [0] pixel_out
    logic                            m_axis_tlast;          // row_end
    logic                            m_axis_tuser;          // [0] frame_end
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [bifr_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [bifr_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    pixel_scoreboard board;

    // idling chances in percent, set by the stimulus process
    int unsigned tx_idle_pct = 10;
    int unsigned rx_idle_pct = 56;

    // the stimulus bumps this to ask the receiver for one long hold-off
    int unsigned hold_requests = 0;

    int unsigned rand_items = 0;
    int unsigned settings   = 0;

    bitmap_invert_flip_rotate #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // receiver: random tready, or a long hold-off counted here when asked
    // ------------------------------------------------------------------------
    int unsigned hold_taken = 0;
    int unsigned hold_left  = 0;

    always @(posedge i_clk) begin
        if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // output monitor: values seen here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready && board != null)
            board.check_result(m_axis_tdata[0], m_axis_tlast, m_axis_tuser);
    end

    // watchdog: ends the run when no beat of any kind moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles, %0d pixels still expected",
                 WATCHDOG_LIMIT, board.pending());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers, all called at a rising edge
    // ------------------------------------------------------------------------

    // offer one beat on the input stream and return at the edge that takes it
    task automatic send_item(input bit action, input bit pix);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {{(bifr_pkg::TDATA_W-1){1'b0}}, pix};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(action, pix);
    endtask

    // drop tvalid and wait until every pixel is out and the block is quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input bifr_pkg::t_cfg_idx idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [6:0] w, input logic [6:0] h,
                             input bit inv, input bit mir, input bit rot);
        wait_idle();
        write_reg(bifr_pkg::CFG_WIDTH,  w);
        write_reg(bifr_pkg::CFG_HEIGHT, h);
        write_reg(bifr_pkg::CFG_INVERT, {6'd0, inv});
        write_reg(bifr_pkg::CFG_MIRROR, {6'd0, mir});
        write_reg(bifr_pkg::CFG_ROTATE, {6'd0, rot});
        settings++;
    endtask

    // receiver idles more in phase 1, sender more in phase 2, neither in phase 3
    function automatic void update_idling();
        if (rand_items < RAND_ITEMS / 3) begin
            tx_idle_pct = 10;
            rx_idle_pct = 56;
        end else if (rand_items < 2 * RAND_ITEMS / 3) begin
            tx_idle_pct = 56;
            rx_idle_pct = 10;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    // a fetch only goes out once the entry it reads has been loaded
    task automatic run_phase(input int unsigned n_items, input int unsigned load_pct);
        bit act;
        bit pix;
        bit dropped;
        int unsigned i;
        for (i = 0; i < n_items; i++) begin
            update_idling();
            pix = $urandom_range(1);
            if (!board.fetch_is_safe())
                act = 1'b0;
            else if (board.can_load())
                act = ($urandom_range(99) < load_pct) ? 1'b0 : 1'b1;
            else
                act = ($urandom_range(99) < 3) ? 1'b0 : 1'b1;  // odd load past the frame
            dropped = (act == 1'b0) && !board.can_load();
            send_item(act, pix);
            if (!dropped) rand_items++;
        end
    endtask

    // frame side: mostly small, sometimes zero, sometimes large or saturating
    function automatic logic [6:0] pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 7'($urandom_range(1, 8));
        if (r < 80) return 7'd0;
        return 7'($urandom_range(9, 127));
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [6:0]  w;
        logic [6:0]  h;
        int unsigned phase_no;
        bit          hold_done;

        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting, 64 x 64: a few loads, then fetches of loaded entries
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);

        // 3 x 2 plain: column counter past the new width restarts, the frame
        // fills up, one load past the frame is dropped, then a whole frame
        configure(7'd3, 7'd2, 1'b0, 1'b0, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b1);
        repeat (6) send_item(1'b1, 1'b0);

        // same frame inverted, mirrored and rotated: 2 wide, 3 tall
        configure(7'd3, 7'd2, 1'b1, 1'b1, 1'b1);
        repeat (6) send_item(1'b1, 1'b1);

        // random part: size extremes first, then random settings
        phase_no  = 0;
        hold_done = 0;
        while (rand_items < RAND_ITEMS) begin
            case (phase_no)
                0: begin w = 7'd127; h = 7'd1;   end
                1: begin w = 7'd0;   h = 7'd127; end
                2: begin w = 7'd64;  h = 7'd2;   end
                3: begin w = 7'd3;   h = 7'd64;  end
                default: begin
                    do begin
                        w = pick_dim();
                        h = pick_dim();
                    end while (pixel_scoreboard::clamp_dim(w, MAX_W) *
                               pixel_scoreboard::clamp_dim(h, MAX_H) > MAX_FRAME_PIX);
                end
            endcase
            configure(w, h, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            if (!hold_done && rand_items >= 2 * RAND_ITEMS / 3) begin
                // receiver stops for a long while, fetches keep coming
                hold_requests++;
                hold_done = 1;
                run_phase(80, 5);
            end else begin
                run_phase($urandom_range(20, 60), 40);
            end
            phase_no++;
        end

        // drain, then give the block time to show any stray beat
        s_axis_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d loads (%0d past the frame), %0d fetches, %0d frame ends",
                 board.loads_taken, board.loads_dropped, board.fetches, board.frames_seen);
        $display("over %0d register settings, %0d mismatches, %0d pixels left over",
                 settings, board.errors, board.pending());
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
src/bifr_pkg.sv
src/bifr_ctrl.sv
src/bifr_datapath.sv
src/bitmap_invert_flip_rotate.sv
src/bifr_checker.sv
bench/bitmap_invert_flip_rotate_test.sv
